>>> hw/rtl/bse_pkg.sv
// Shared types and constants for the binary search engine.
// No dependencies; imported by bse_search, binary_search_engine and the bench.
package bse_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    // Bounds range over 0 .. TABLE_DEPTH inclusive
    localparam int BOUND_W     = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;
    localparam int PROBE_W = 3;

    localparam logic [PROBE_W-1:0] PROBE_MAX = 3'd7;

    // Request kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // Result handed from the search sequencer to the output stage
    typedef struct packed {
        logic               valid;
        logic               found;
        logic [PROBE_W-1:0] probes;
    } search_res_t;

endpackage

>>> hw/rtl/bse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/bse_search.sv
// Binary search sequencer: one probe at a time through the table RAM
// read port and a single signed compare. Depends on bse_pkg.
module bse_search
    import bse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // search request
    input  logic               start,
    input  logic [VALUE_W-1:0] key,
    input  logic [BOUND_W-1:0] count,
    output logic               busy,
    // table read port
    output logic               rd_en,
    output logic [ADDR_W-1:0]  rd_addr,
    input  logic [VALUE_W-1:0] rd_data,
    // result
    output search_res_t        res,
    input  logic               res_take
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADDR = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]         state_reg,  state_next;
    logic [BOUND_W-1:0] left_reg,   left_next;
    logic [BOUND_W-1:0] hi_reg,     hi_next;    // one past the right bound
    logic [BOUND_W-1:0] mid_reg,    mid_next;
    logic [VALUE_W-1:0] key_reg,    key_next;
    logic [PROBE_W-1:0] probe_reg,  probe_next;
    logic               found_reg,  found_next;
    logic [BOUND_W:0]   mid_sum;
    logic [BOUND_W-1:0] mid_calc;

    // mid = floor((left + right) / 2) with right = hi - 1
    assign mid_sum  = {1'b0, left_reg} + {1'b0, hi_reg} - {{BOUND_W{1'b0}}, 1'b1};
    assign mid_calc = mid_sum[BOUND_W:1];

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        probe_next = probe_reg;
        found_next = found_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next   = key;
                    left_next  = '0;
                    hi_next    = count;
                    probe_next = '0;
                    found_next = 1'b0;
                    state_next = (count == '0) ? S_DONE : S_ADDR;
                end
            end
            S_ADDR:
            begin
                mid_next   = mid_calc;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (probe_reg != PROBE_MAX)
                begin
                    probe_next = probe_reg + 1'b1;
                end
                if (rd_data == key_reg)
                begin
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    if ($signed(rd_data) < $signed(key_reg))
                    begin
                        left_next = mid_reg + 1'b1;
                    end
                    else
                    begin
                        hi_next = mid_reg;
                    end
                    state_next = (left_next < hi_next) ? S_ADDR : S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        key_reg   <= key_next;
        probe_reg <= probe_next;
        found_reg <= found_next;
    end

    // Probe address goes out in the address state
    assign rd_en   = (state_reg == S_ADDR);
    assign rd_addr = ADDR_W'(mid_calc);

    assign busy       = (state_reg != S_IDLE);
    assign res.valid  = (state_reg == S_DONE);
    assign res.found  = found_reg;
    assign res.probes = probe_reg;

    // Checks
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == S_IDLE)
        else $error("search started while busy");

    a_window_open: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ADDR |-> left_reg < hi_reg)
        else $error("probe issued on an empty window");

    a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> (mid_reg >= left_reg) && (mid_reg < hi_reg))
        else $error("probe outside the search window");

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res_take) |=> state_reg == S_IDLE)
        else $error("sequencer did not return to idle after result");

endmodule

>>> hw/rtl/binary_search_engine.sv
// Binary search engine: request handshake, entry count register, table
// RAM and output register around the search sequencer.
// Depends on bse_pkg, bse_ram and bse_search.
//
// A write request (tuser 0) stores a signed 32-bit entry and is taken
// with no result. A search request (tuser 1) runs a binary search over
// entries 0 .. min(entry_count, 64) - 1, which must be sorted ascending,
// and returns one result with a found flag and the probe count. Each
// probe passes through an address state, which issues the registered
// read of the table RAM, and then a compare state. The block accepts no
// request while a search runs. A finished result waits in the output
// register without holding up the next request; if that register is
// still full when the next search finishes, the block stays busy until
// it drains. Write entry_count only while the block is idle.
module binary_search_engine
    import bse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [COUNT_W-1:0]   cfg_wr_data,   // entry_count
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,       // [5:0] entry_index, [37:6] item_value
    input  logic                 s_tuser,       // kind
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata        // [0] found, [3:1] probe_count
);

    logic [COUNT_W-1:0] count_reg;
    logic [BOUND_W-1:0] eff_count;
    logic               out_valid_reg;
    logic               out_found_reg;
    logic [PROBE_W-1:0] out_probe_reg;
    logic               accept;
    logic [INDEX_W-1:0] in_index;
    logic [VALUE_W-1:0] in_value;
    logic               wr_en;
    logic               start;
    logic               busy;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [VALUE_W-1:0] rd_data;
    logic               res_take;
    search_res_t        res;

    // Entry count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            count_reg <= cfg_wr_data;
        end
    end

    // Counts above the table depth saturate
    assign eff_count = (32'(count_reg) > 32'(TABLE_DEPTH)) ? BOUND_W'(TABLE_DEPTH)
                                                           : BOUND_W'(count_reg);

    // Request decode
    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;
    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_value = s_tdata[INDEX_W+VALUE_W-1:INDEX_W];
    assign wr_en    = accept && (s_tuser == KIND_WRITE)
                      && (32'(in_index) < 32'(TABLE_DEPTH));
    assign start    = accept && (s_tuser == KIND_SEARCH);

    bse_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(in_index)),
        .wr_data (in_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bse_search u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .key      (in_value),
        .count    (eff_count),
        .busy     (busy),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .res      (res),
        .res_take (res_take)
    );

    // Output register: loads when empty or being drained
    assign res_take = res.valid && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_found_reg <= res.found;
            out_probe_reg <= res.probes;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_probe_reg, out_found_reg};

    // Checks
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !res_take)
        else $error("pending result overwritten");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> !res.valid)
        else $error("search result delivered twice");

    a_write_no_search: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && busy))
        else $error("table write during a search");

endmodule

>>> sim/binary_search_engine_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for binary_search_engine: loads sorted tables, runs searches
// under several entry_count settings and checks every result against a local predictor.
// Depends on bse_pkg and the binary_search_engine RTL.
module binary_search_engine_tb
    import bse_pkg::*;
();

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_BOUND   = 20000;
    localparam int ITEM_TARGET  = 1600;
    localparam int MAX_GAP      = 18;
    localparam int MAX_PRINTS   = 30;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic                      kind;
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic               found;
        logic [PROBE_W-1:0] probes;
    } outcome_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [39:0]        s_tdata     = '0;   // [5:0] entry_index, [37:6] item_value
    logic               s_tuser     = 1'b0; // kind
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [7:0]         m_tdata;            // [0] found, [3:1] probe_count

    // Pending requests and the search outcomes still owed by the block
    request_t request_queue[$];
    outcome_t expected_outcomes[$];

    // Predictor state: the table is updated as requests are accepted, the count when it is written
    logic signed [VALUE_W-1:0] shadow_table [TABLE_DEPTH];
    logic [COUNT_W-1:0]        shadow_count = '0;

    // Stimulus-side view of the table, used to choose search keys
    logic signed [VALUE_W-1:0] plan_table [TABLE_DEPTH];
    int                        plan_count = 0;

    int   items_sent  = 0;
    int   error_count = 0;
    int   send_gap    = 0;
    int   recv_stall  = 0;
    logic send_steady = 1'b0;
    logic recv_steady = 1'b0;

    binary_search_engine u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    task automatic report_mismatch(string msg);
        if (error_count < MAX_PRINTS)
            $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Binary search over the first min(entry_count, depth) entries
    function automatic outcome_t predict_search(logic signed [VALUE_W-1:0] key);
        int       n;
        int       left;
        int       right;
        int       mid;
        int       probes;
        outcome_t res;
        n      = (int'(shadow_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
        left   = 0;
        right  = n - 1;
        probes = 0;
        res.found = 1'b0;
        while (left <= right)
        begin
            probes++;
            mid = (left + right) / 2;
            if (shadow_table[mid] == key)
            begin
                res.found = 1'b1;
                break;
            end
            else if (shadow_table[mid] < key)
                left = mid + 1;
            else
                right = mid - 1;
        end
        res.probes = (probes > int'(PROBE_MAX)) ? PROBE_MAX : probes[PROBE_W-1:0];
        return res;
    endfunction

    function automatic int draw_gap(logic steady);
        return steady ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Request driver: applies accepted requests to the predictor, then offers the next
    always @(posedge clk)
    begin
        request_t next_req;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == KIND_WRITE)
                    shadow_table[s_tdata[INDEX_W-1:0]] = s_tdata[INDEX_W +: VALUE_W];
                else
                    expected_outcomes.push_back(predict_search(s_tdata[INDEX_W +: VALUE_W]));
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    next_req = request_queue.pop_front();
                    s_tuser  <= next_req.kind;
                    s_tdata  <= {2'b00, next_req.value, next_req.index};
                    s_tvalid <= 1'b1;
                    send_gap <= draw_gap(send_steady);
                end
                else
                    s_tvalid <= 1'b0;
            end
            if ($urandom_range(0, 99) == 0)
                send_steady <= ~send_steady;
        end
    end

    // Result monitor: random stall after each result, checks against the oldest expectation
    always @(posedge clk)
    begin
        outcome_t want;
        int       stall;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_outcomes.size() == 0)
                    report_mismatch($sformatf("result %h with none expected", m_tdata));
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (m_tdata[0] !== want.found)
                        report_mismatch($sformatf("found %b, expected %b",
                                                  m_tdata[0], want.found));
                    if (m_tdata[PROBE_W:1] !== want.probes)
                        report_mismatch($sformatf("probe_count %0d, expected %0d",
                                                  m_tdata[PROBE_W:1], want.probes));
                end
                stall = draw_gap(recv_steady);
                recv_stall <= stall;
                m_tready   <= (stall == 0);
            end
            else if (recv_stall > 0)
            begin
                recv_stall <= recv_stall - 1;
                m_tready   <= (recv_stall == 1);
            end
            else
                m_tready <= 1'b1;
            if ($urandom_range(0, 99) == 0)
                recv_steady <= ~recv_steady;
        end
    end

    task automatic push_write(int index, logic signed [VALUE_W-1:0] value);
        request_t req;
        req.kind  = KIND_WRITE;
        req.index = index[INDEX_W-1:0];
        req.value = value;
        request_queue.push_back(req);
        plan_table[index] = value;
        items_sent++;
    endtask

    task automatic push_search(logic signed [VALUE_W-1:0] key);
        request_t req;
        req.kind  = KIND_SEARCH;
        req.index = INDEX_W'($urandom);
        req.value = key;
        request_queue.push_back(req);
        items_sent++;
    endtask

    // Hold off until every request is taken and every result is back, then let the block settle
    task automatic wait_idle();
        int waited;
        waited = 0;
        @(negedge clk);
        while ((request_queue.size() != 0 || s_tvalid || expected_outcomes.size() != 0)
               && waited < IDLE_BOUND)
        begin
            @(negedge clk);
            waited++;
        end
        if (expected_outcomes.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", expected_outcomes.size()));
            expected_outcomes.delete();
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_entry_count(int value);
        wait_idle();
        @(posedge clk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= value[COUNT_W-1:0];
        shadow_count  = value[COUNT_W-1:0];
        plan_count    = (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Load all entries with a sorted set of values in one of a few spreads
    task automatic fill_sorted();
        int vals[$];
        int style;
        int base;
        style = $urandom_range(0, 3);
        base  = $urandom;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            case (style)
                0:       vals.push_back($urandom);
                1:       vals.push_back(base + $urandom_range(0, 150));  // dense, duplicates
                2:       vals.push_back($urandom_range(0, 2000) - 1000);
                default: vals.push_back($urandom);
            endcase
        end
        if (style == 3)
        begin
            vals[0] = VALUE_MIN;
            vals[1] = VALUE_MAX;
        end
        vals.sort();
        if ($urandom_range(0, 1))
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                push_write(i, vals[i]);
        end
        else
        begin
            for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                push_write(i, vals[i]);
        end
    endtask

    // About half the keys present in the active range, some near misses, extremes and noise
    function automatic logic signed [VALUE_W-1:0] pick_key();
        int sel;
        int idx;
        sel = $urandom_range(0, 99);
        idx = (plan_count > 0) ? $urandom_range(0, plan_count - 1) : 0;
        if (sel < 50 && plan_count > 0)
            return plan_table[idx];
        else if (sel < 70 && plan_count > 0)
            return plan_table[idx] + ($urandom_range(0, 1) ? 1 : -1);
        else if (sel < 78)
            return $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
        else
            return $urandom;
    endfunction

    // Stimulus
    initial
    begin
        int first_counts[6];
        int phase;
        int n_items;
        int sel;
        int idx;
        first_counts = '{64, 127, 65, 0, 1, 2};
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table straight after reset
        push_search(32'sd0);
        push_search(VALUE_MIN);

        // Small sorted table spanning the full value range
        push_write(0, VALUE_MIN);
        push_write(1, -32'sd5);
        push_write(2, 32'sd0);
        push_write(3, 32'sd7);
        push_write(4, 32'sd1000);
        push_write(5, 32'sd123456);
        push_write(6, 32'sh7fff_fffe);
        push_write(7, VALUE_MAX);
        set_entry_count(8);
        push_search(VALUE_MIN);
        push_search(VALUE_MAX);
        push_search(32'sd7);
        push_search(32'sd123456);
        push_search(-32'sd6);
        push_search(32'sh7fff_fffd);
        push_search(32'sd1);

        // Single entry, then back to empty
        set_entry_count(1);
        push_search(VALUE_MIN);
        push_search(VALUE_MAX);
        set_entry_count(0);
        push_search(VALUE_MIN);

        // Random phases; every entry is written from here on
        fill_sorted();
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 99);
            if (phase < 6)
                set_entry_count(first_counts[phase]);
            else if (sel < 10)
                set_entry_count($urandom_range(TABLE_DEPTH + 1, 127));
            else if (sel < 25)
                set_entry_count(TABLE_DEPTH);
            else
                set_entry_count($urandom_range(0, TABLE_DEPTH));
            if ($urandom_range(0, 1))
                fill_sorted();
            n_items = $urandom_range(30, 80);
            repeat (n_items)
            begin
                sel = $urandom_range(0, 99);
                idx = $urandom_range(0, TABLE_DEPTH - 1);
                if (sel < 10)
                    push_write(idx, (idx > 0) ? plan_table[idx - 1] : plan_table[idx]);
                else if (sel < 20)
                    push_write(idx, $urandom);  // may break the ordering
                else
                    push_search(pick_key());
            end
            phase++;
        end

        wait_idle();
        if (error_count == 0)
            $display("binary_search_engine_tb OK");
        else
            $display("binary_search_engine_tb NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(20_000_000);
        $display("binary_search_engine_tb NOT OK");
        $finish;
    end

endmodule

>>> binary_search_engine.f
hw/rtl/bse_pkg.sv
hw/rtl/bse_ram.sv
hw/rtl/bse_search.sv
hw/rtl/binary_search_engine.sv
sim/binary_search_engine_tb.sv
